[rtl/core/sdfb_pkg.sv]
// ----------------------------------------------------------------------------
// sdfb_pkg
// Shared types, codes and segment tables for the segment display frame builder.
// ----------------------------------------------------------------------------
`default_nettype none

package sdfb_pkg;

  // Input operation codes, carried on tuser
  typedef enum logic [1:0] {
    OP_NUMBER  = 2'd0,
    OP_CLOCK   = 2'd1,
    OP_CONTROL = 2'd2,
    OP_IGNORE  = 2'd3
  } op_e;

  // Configuration register indexes
  localparam logic [1:0] CFG_BRIGHTNESS = 2'd0;
  localparam logic [1:0] CFG_DISPLAY_ON = 2'd1;
  localparam logic [1:0] CFG_FILL_ZEROS = 2'd2;

  // Fixed command bytes of a frame
  localparam logic [7:0] CMD_AUTO_ADDR  = 8'h40;
  localparam logic [7:0] CMD_START_ADDR = 8'hC0;
  localparam logic [7:0] CMD_CTRL_BASE  = 8'h80;
  localparam logic [7:0] CTRL_ON_BIT    = 8'h08;

  // Special segment patterns
  localparam logic [7:0] SEG_POINT     = 8'h80;
  localparam logic [7:0] SEG_MINUS     = 8'h40;
  localparam logic [7:0] SEG_MINUS_ONE = 8'h46;
  localparam logic [7:0] SEG_BLANK     = 8'h00;

  // Reciprocal of ten for a 16-bit dividend: q = (m * RECIP_TEN) >> RECIP_SHIFT
  localparam logic [31:0] RECIP_TEN   = 32'd52429;
  localparam int unsigned RECIP_SHIFT = 19;

  // Clock drawn as hours*100 + minutes, point under the hundreds digit
  localparam logic [15:0] HOUR_SCALE = 16'd100;
  localparam logic [2:0]  CLOCK_POINT = 3'd2;

  typedef struct packed {
    logic [2:0] brightness;
    logic       display_on;
    logic       fill_zeros;
  } cfg_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

  function automatic logic [7:0] seg_code(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0:    s = 8'h3f;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5b;
      4'd3:    s = 8'h4f;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6d;
      4'd6:    s = 8'h7d;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7f;
      4'd9:    s = 8'h6f;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

  function automatic logic [7:0] ctrl_byte(input cfg_t cfg);
    return CMD_CTRL_BASE | {5'd0, cfg.brightness} | (cfg.display_on ? CTRL_ON_BIT : 8'h00);
  endfunction

endpackage

`default_nettype wire

[rtl/core/sdfb_front.sv]
// ----------------------------------------------------------------------------
// sdfb_front
// Accepts items, classifies them and converts numbers to segment bytes,
// one decimal digit per cycle, then queues the frame entry when there is room.
// ----------------------------------------------------------------------------
`default_nettype none

module sdfb_front import sdfb_pkg::*; #(
  parameter int unsigned DIGITS = 4
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire cfg_t                cfg_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [1:0]          in_op_i,
  input  wire logic [15:0]         in_value_i,
  input  wire logic [2:0]          in_point_pos_i,
  input  wire logic [4:0]          in_hours_i,
  input  wire logic [5:0]          in_minutes_i,
  input  wire fifo_stat_t          fifo_stat_i,
  output logic                     push_o,
  output logic [8*DIGITS:0]        push_data_o
);

  localparam int unsigned IW = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam logic [IW-1:0] TOP_IDX = IW'(DIGITS - 1);

  logic            busy_q, busy_d;
  logic [IW-1:0]   idx_q, idx_d;
  logic [15:0]     mag_q, mag_d;
  logic            neg_q, neg_d;
  logic [2:0]      pp_q, pp_d;
  logic [7:0]      seg_q [DIGITS];
  logic [7:0]      seg_d [DIGITS];

  logic            accept;
  logic            last_digit;
  logic [31:0]     prod;
  logic [15:0]     quot;
  logic [15:0]     tenq;
  logic [15:0]     diff;
  logic [7:0]      digit_seg;
  logic [7:0]      shifted [DIGITS];
  logic [8*DIGITS-1:0] seg_vec;

  assign in_ready_o = !busy_q && !fifo_stat_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign last_digit = (idx_q == TOP_IDX);

  // Divide the running magnitude by ten
  assign prod = 32'(mag_q) * RECIP_TEN;
  assign quot = 16'(prod[31:RECIP_SHIFT]);
  assign tenq = {quot[12:0], 3'b000} + {quot[14:0], 1'b0};
  assign diff = mag_q - tenq;

  always_comb begin
    if (!cfg_i.fill_zeros && (mag_q == 16'd0) && (3'(idx_q) > pp_q)) begin
      digit_seg = SEG_BLANK;
    end else begin
      digit_seg = seg_code(diff[3:0]);
    end
    if ((pp_q != 3'd0) && (3'(idx_q) == pp_q)) begin
      digit_seg = digit_seg | SEG_POINT;
    end
    if (last_digit && neg_q) begin
      digit_seg = (mag_q != 16'd0) ? SEG_MINUS_ONE : SEG_MINUS;
    end
  end

  // New digit enters at the most significant slot; older ones move down
  always_comb begin
    shifted[0] = digit_seg;
    for (int j = 1; j < DIGITS; j++) begin
      shifted[j] = seg_q[j-1];
    end
  end

  for (genvar g = 0; g < DIGITS; g++) begin : g_pack
    assign seg_vec[8*g +: 8] = shifted[g];
  end

  always_comb begin
    busy_d      = busy_q;
    idx_d       = idx_q;
    mag_d       = mag_q;
    neg_d       = neg_q;
    pp_d        = pp_q;
    seg_d       = seg_q;
    push_o      = 1'b0;
    push_data_o = {1'b0, seg_vec};
    if (busy_q) begin
      if (!last_digit) begin
        seg_d = shifted;
        mag_d = quot;
        idx_d = idx_q + IW'(1);
      end else if (!fifo_stat_i.full) begin
        push_o      = 1'b1;
        push_data_o = {1'b1, seg_vec};
        busy_d      = 1'b0;
      end
    end else if (accept) begin
      unique case (op_e'(in_op_i))
        OP_NUMBER: begin
          busy_d = 1'b1;
          idx_d  = '0;
          neg_d  = in_value_i[15];
          mag_d  = in_value_i[15] ? (16'd0 - in_value_i) : in_value_i;
          pp_d   = in_point_pos_i;
        end
        OP_CLOCK: begin
          busy_d = 1'b1;
          idx_d  = '0;
          neg_d  = 1'b0;
          mag_d  = 16'(16'(in_hours_i) * HOUR_SCALE) + 16'(in_minutes_i);
          pp_d   = CLOCK_POINT;
        end
        OP_CONTROL: begin
          push_o      = 1'b1;
          push_data_o = {1'b0, seg_vec};
        end
        OP_IGNORE: begin
          push_o = 1'b0;
        end
        default: begin
          push_o = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    neg_q <= neg_d;
    pp_q  <= pp_d;
    seg_q <= seg_d;
  end

endmodule

`default_nettype wire

[rtl/core/sdfb_fifo.sv]
// ----------------------------------------------------------------------------
// sdfb_fifo
// Two-entry queue of frame entries between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module sdfb_fifo import sdfb_pkg::*; #(
  parameter int unsigned WIDTH = 33
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] push_data_i,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      head_o,
  output fifo_stat_t            stat_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       count_q;

  assign head_o       = mem_q[rd_ptr_q];
  assign stat_o.empty = (count_q == 2'd0);
  assign stat_o.full  = (count_q == 2'd2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

[rtl/core/sdfb_back.sv]
// ----------------------------------------------------------------------------
// sdfb_back
// Walks each queued entry byte by byte and drives the registered output.
// ----------------------------------------------------------------------------
`default_nettype none

module sdfb_back import sdfb_pkg::*; #(
  parameter int unsigned DIGITS = 4
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cfg_t              cfg_i,
  input  wire logic [8*DIGITS:0] head_i,
  input  wire fifo_stat_t        fifo_stat_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [7:0]             out_byte_o,
  output logic                   out_start_o,
  output logic                   out_stop_o,
  output logic                   out_last_o
);

  localparam int unsigned IW = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int unsigned PW = $clog2(DIGITS + 3);
  localparam logic [PW-1:0] POS_CTRL     = PW'(DIGITS + 2);
  localparam logic [PW-1:0] POS_LAST_SEG = PW'(DIGITS + 1);

  logic [PW-1:0] pos_q, pos_d;
  logic          valid_q, valid_d;
  logic [7:0]    byte_q, byte_d;
  logic          start_q, start_d;
  logic          stop_q, stop_d;
  logic          last_q, last_d;

  logic          advance;
  logic          is_num;
  logic [PW-1:0] pos_m2;
  logic [IW-1:0] dig_sel;

  assign is_num  = head_i[8*DIGITS];
  assign advance = !fifo_stat_i.empty && (!valid_q || out_ready_i);
  assign pos_m2  = pos_q - PW'(2);
  assign dig_sel = pos_m2[IW-1:0];

  always_comb begin
    pos_d   = pos_q;
    byte_d  = byte_q;
    start_d = start_q;
    stop_d  = stop_q;
    last_d  = last_q;
    pop_o   = 1'b0;
    valid_d = valid_q && !out_ready_i;
    if (advance) begin
      valid_d = 1'b1;
      if (!is_num || (pos_q == POS_CTRL)) begin
        byte_d  = ctrl_byte(cfg_i);
        start_d = 1'b1;
        stop_d  = 1'b1;
        last_d  = 1'b1;
        pop_o   = 1'b1;
        pos_d   = '0;
      end else if (pos_q == PW'(0)) begin
        byte_d  = CMD_AUTO_ADDR;
        start_d = 1'b1;
        stop_d  = 1'b1;
        last_d  = 1'b0;
        pos_d   = pos_q + PW'(1);
      end else if (pos_q == PW'(1)) begin
        byte_d  = CMD_START_ADDR;
        start_d = 1'b1;
        stop_d  = 1'b0;
        last_d  = 1'b0;
        pos_d   = pos_q + PW'(1);
      end else begin
        byte_d  = head_i[8*dig_sel +: 8];
        start_d = 1'b0;
        stop_d  = (pos_q == POS_LAST_SEG);
        last_d  = 1'b0;
        pos_d   = pos_q + PW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q  <= byte_d;
    start_q <= start_d;
    stop_q  <= stop_d;
    last_q  <= last_d;
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign out_start_o = start_q;
  assign out_stop_o  = stop_q;
  assign out_last_o  = last_q;

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= POS_CTRL)
    else $error("byte position past end of frame");

  a_pos_has_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q != PW'(0) |-> !fifo_stat_i.empty)
    else $error("frame in progress without a queued entry");

  a_last_framed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && last_q |-> start_q && stop_q)
    else $error("final byte lacks start or stop framing");

endmodule

`default_nettype wire

[rtl/core/segment_display_frame_builder_core.sv]
// ----------------------------------------------------------------------------
// segment_display_frame_builder_core
// Builds command byte frames for a serial seven-segment driver.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request per transaction: tuser selects number, clock,
//   control resend or ignore; tdata carries value, point position, hours and
//   minutes. m_axis returns the frame one byte per transaction, with start
//   and stop framing on tuser and tlast on the control byte that ends it.
//   cfg_* writes brightness, display enable and zero fill; write it only
//   while no frame is in flight. cfg_ready_o is always high.
// Throughput:
//   A number or clock request is converted in full and queued before its
//   first byte shows, and then emits DIGITS+3 bytes (7 for four digits),
//   one per cycle while the receiver is ready. The front converts one digit
//   per cycle through a single multiply-by-reciprocal unit, which keeps it
//   ahead of the byte sequencer, which sets the rate. A control resend is
//   one byte. A two-entry queue lets the next request be converted while
//   the current frame drains.
// Reset clears all control state and loads brightness 7, display on and
// zero fill off. When the receiver stalls, the output register holds its
// byte, the queue fills, and s_axis_tready_o drops.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_display_frame_builder_core import sdfb_pkg::*; #(
  parameter int unsigned DIGITS = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Request stream
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // [15:0] value, [18:16] point_pos, [23:19] hours, [29:24] minutes, [31:30] zero
  input  wire logic [31:0] s_axis_tdata_i,
  // [1:0] op
  input  wire logic [1:0]  s_axis_tuser_i,
  // Frame byte stream
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [7:0] wire_byte
  output logic [7:0]       m_axis_tdata_o,
  // [0] start_before, [1] stop_after
  output logic [1:0]       m_axis_tuser_o,
  output logic             m_axis_tlast_o,
  // Configuration writes
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [7:0]  cfg_data_i
);

  localparam int unsigned EW = 8 * DIGITS + 1;

  cfg_t       cfg_q, cfg_d;
  fifo_stat_t fifo_stat;
  logic       push;
  logic [EW-1:0] push_data;
  logic       pop;
  logic [EW-1:0] head;
  logic       out_start;
  logic       out_stop;

  // Configuration registers: always ready, unknown indexes are dropped
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_BRIGHTNESS: cfg_d.brightness = cfg_data_i[2:0];
        CFG_DISPLAY_ON: cfg_d.display_on = cfg_data_i[0];
        CFG_FILL_ZEROS: cfg_d.fill_zeros = cfg_data_i[0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.brightness <= 3'd7;
      cfg_q.display_on <= 1'b1;
      cfg_q.fill_zeros <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front: classify requests and convert to segment bytes
  sdfb_front #(
    .DIGITS (DIGITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .in_valid_i     (s_axis_tvalid_i),
    .in_ready_o     (s_axis_tready_o),
    .in_op_i        (s_axis_tuser_i),
    .in_value_i     (s_axis_tdata_i[15:0]),
    .in_point_pos_i (s_axis_tdata_i[18:16]),
    .in_hours_i     (s_axis_tdata_i[23:19]),
    .in_minutes_i   (s_axis_tdata_i[29:24]),
    .fifo_stat_i    (fifo_stat),
    .push_o         (push),
    .push_data_o    (push_data)
  );

  // Queue of finished entries: kind bit on top, segment bytes below
  sdfb_fifo #(
    .WIDTH (EW)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .stat_o      (fifo_stat)
  );

  // Back: sequence the frame bytes into the output register
  sdfb_back #(
    .DIGITS (DIGITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .head_i      (head),
    .fifo_stat_i (fifo_stat),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_byte_o  (m_axis_tdata_o),
    .out_start_o (out_start),
    .out_stop_o  (out_stop),
    .out_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tuser_o = {out_stop, out_start};

endmodule

`default_nettype wire
